### sv/mips_relocation_patcher_unit_macros.svh
// Assertion macros shared by the relocation patcher modules.
`ifndef MIPS_RELOCATION_PATCHER_UNIT_MACROS_SVH
`define MIPS_RELOCATION_PATCHER_UNIT_MACROS_SVH

`ifndef SYNTH
`define MRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MRP_ASSERT(label, clk, rst_n, prop, msg)
`define MRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/mrp_pkg.sv
package mrp_pkg;

	localparam int SEGMENTS_DEF = 32;

	// result queue geometry (power of two)
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// request function codes
	localparam logic [1:0] FUNC_SET_BASE = 2'd0;
	localparam logic [1:0] FUNC_SECTION  = 2'd1;
	localparam logic [1:0] FUNC_APPLY    = 2'd2;

	// relocation types
	localparam logic [7:0] RT_R16   = 8'd1;
	localparam logic [7:0] RT_R32   = 8'd2;
	localparam logic [7:0] RT_REL32 = 8'd3;
	localparam logic [7:0] RT_R26   = 8'd4;
	localparam logic [7:0] RT_HI16  = 8'd5;
	localparam logic [7:0] RT_LO16  = 8'd6;

	typedef struct packed {
		logic [1:0]  func;
		logic [4:0]  seg_index;
		logic [31:0] base_value;
		logic [7:0]  reloc_type;
		logic [4:0]  symbol_index;
		logic [31:0] target_offset;
		logic [31:0] target_value;
	} req_t;

	typedef struct packed {
		logic [31:0] write_addr;
		logic [31:0] write_data;
		logic        write_half;
		logic        last;
	} res_t;

	// up to two results pushed per cycle; v1 only together with v0
	typedef struct packed {
		logic v0;
		logic v1;
		res_t e0;
		res_t e1;
	} res_push_t;

	function automatic int seg_idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

### sv/mrp_seg_mem.sv
module mrp_seg_mem import mrp_pkg::*; #(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [seg_idx_w(SEGMENTS)-1:0] wr_idx,
	input  logic [31:0]                    wr_data,
	input  logic                           rd_en,
	input  logic [seg_idx_w(SEGMENTS)-1:0] rd_idx_a,
	input  logic [seg_idx_w(SEGMENTS)-1:0] rd_idx_b,
	output logic [31:0]                    rd_data_a,
	output logic [31:0]                    rd_data_b
);

	logic [31:0] mem [SEGMENTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_idx_a];
			rd_data_b <= mem[rd_idx_b];
		end
	end

endmodule

### sv/mrp_reloc_pipe.sv
`include "mips_relocation_patcher_unit_macros.svh"

module mrp_reloc_pipe import mrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  req_t        req,
	input  logic        seg_ok,
	input  logic        sym_ok,
	input  logic [31:0] seg_base,
	input  logic [31:0] sym_base,
	output res_push_t   push,
	output logic [1:0]  stage_busy
);

	// stage 1: table data arrives
	logic        v_s1;
	logic [1:0]  func_s1;
	logic [7:0]  type_s1;
	logic [31:0] off_s1;
	logic [31:0] tv_s1;
	logic        seg_ok_s1;
	logic        sym_ok_s1;

	// stage 2: final data and queue push
	logic        v_s2;
	logic [1:0]  func_s2;
	logic [7:0]  type_s2;
	logic [31:0] addr_s2;
	logic [31:0] sum_s2;
	logic [5:0]  tv_top_s2;

	logic [15:0] hi_value_q;
	logic [31:0] hi_address_q;
	logic        hi_pending_q;

	logic [31:0] base_c;
	logic [31:0] sym_c;
	logic [31:0] operand_c;
	logic [31:0] addr_c;
	logic [31:0] sum_c;
	logic        apply_s2;
	logic [15:0] hi_up_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= req.func;
			type_s1   <= req.reloc_type;
			off_s1    <= req.target_offset;
			tv_s1     <= req.target_value;
			seg_ok_s1 <= seg_ok;
			sym_ok_s1 <= sym_ok;
		end
	end

	always_comb begin
		base_c = seg_ok_s1 ? seg_base : 32'd0;
		sym_c  = sym_ok_s1 ? sym_base : 32'd0;
		case (type_s1)
			RT_R16:  operand_c = {16'd0, tv_s1[15:0]};
			RT_R26:  operand_c = {tv_s1[29:0], 2'b00};
			RT_LO16: operand_c = {hi_value_q, tv_s1[15:0]};
			default: operand_c = tv_s1;
		endcase
		addr_c = base_c + off_s1;
		sum_c  = sym_c + operand_c;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			func_s2   <= func_s1;
			type_s2   <= type_s1;
			addr_s2   <= addr_c;
			sum_s2    <= sum_c;
			tv_top_s2 <= tv_s1[31:26];
		end
	end

	// hi_value is used by LO16 in stage 1, so record it there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_value_q <= 16'd0;
		end else if (v_s1 && func_s1 == FUNC_APPLY && type_s1 == RT_HI16) begin
			hi_value_q <= tv_s1[15:0];
		end
	end

	assign apply_s2 = v_s2 && func_s2 == FUNC_APPLY;
	assign hi_up_c  = sum_s2[31:16] + {15'd0, sum_s2[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_address_q <= 32'd0;
			hi_pending_q <= 1'b0;
		end else if (v_s2 && func_s2 == FUNC_SECTION) begin
			hi_address_q <= 32'd0;
			hi_pending_q <= 1'b0;
		end else if (apply_s2 && type_s2 == RT_HI16) begin
			hi_address_q <= addr_s2;
			hi_pending_q <= 1'b1;
		end else if (apply_s2 && type_s2 == RT_LO16) begin
			hi_pending_q <= 1'b0;
		end
	end

	always_comb begin
		push.v0 = 1'b0;
		push.v1 = 1'b0;
		push.e0 = '{write_addr: addr_s2, write_data: sum_s2, write_half: 1'b0, last: 1'b1};
		push.e1 = '{write_addr: addr_s2, write_data: {16'd0, sum_s2[15:0]},
			write_half: 1'b1, last: 1'b1};
		if (apply_s2) begin
			case (type_s2)
				RT_R16: begin
					push.v0 = 1'b1;
					push.e0.write_data = {16'd0, sum_s2[15:0]};
					push.e0.write_half = 1'b1;
				end
				RT_R32: begin
					push.v0 = 1'b1;
				end
				RT_REL32: begin
					push.v0 = 1'b1;
					push.e0.write_data = sum_s2 - addr_s2;
				end
				RT_R26: begin
					push.v0 = 1'b1;
					push.e0.write_data = {tv_top_s2, sum_s2[27:2]};
				end
				RT_LO16: begin
					push.v0 = 1'b1;
					if (hi_pending_q) begin
						// carry-adjusted HI half goes first
						push.v1 = 1'b1;
						push.e0 = '{write_addr: hi_address_q, write_data: {16'd0, hi_up_c},
							write_half: 1'b1, last: 1'b0};
					end else begin
						push.e0 = push.e1;
					end
				end
				default: begin
					push.v0 = 1'b0;
				end
			endcase
		end
	end

	assign stage_busy = {v_s2, v_s1};

	`MRP_ASSERT_IMP(a_pair_order, clk, arst_n, push.v1, push.v0, "second result without first")
	`MRP_ASSERT_IMP(a_pair_lo16, clk, arst_n, push.v1,
		(type_s2 == RT_LO16 && hi_pending_q && !push.e0.last), "pair outside pending LO16")

endmodule

### sv/mrp_result_fifo.sv
`include "mips_relocation_patcher_unit_macros.svh"

module mrp_result_fifo import mrp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  res_push_t            push,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res_data,
	output logic [RES_CNT_W-1:0] fill
);

	res_t                 entries [RES_DEPTH];
	logic [RES_PTR_W-1:0] head_q;
	logic [RES_PTR_W-1:0] tail_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 pop;

	assign pop = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			entries[tail_q] <= push.e0;
		end
		if (push.v1) begin
			entries[tail_q + RES_PTR_W'(1)] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + RES_PTR_W'(push.v0) + RES_PTR_W'(push.v1);
			head_q  <= head_q + RES_PTR_W'(pop);
			count_q <= count_q + RES_CNT_W'(push.v0) + RES_CNT_W'(push.v1)
				- RES_CNT_W'(pop);
		end
	end

	assign res_valid = count_q != '0;
	assign res_data  = entries[head_q];
	assign fill      = count_q;

	`MRP_ASSERT(a_fill_bound, clk, arst_n, count_q <= RES_CNT_W'(RES_DEPTH), "result queue overflow")

endmodule

### sv/mips_relocation_patcher_unit.sv
// A result is offered once its request has passed the table read, the address/sum add
// and the final adjust and queue push, earlier results permitting.
// Throughput: one request per cycle when not stalled; a LO16 resolving a HI16 yields
// two writes; the result port moves one per cycle unless stalled, pacing such runs.
// Reset (arst_n low): clears pipeline valids, result queue and HI16 record; the segment
// base table is not cleared and reads as garbage until each entry is set.
`include "mips_relocation_patcher_unit_macros.svh"

module mips_relocation_patcher_unit import mrp_pkg::*; #(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	localparam int IDX_W = seg_idx_w(SEGMENTS);

	logic                 accept;
	logic [8:0]           seg_ext;
	logic [8:0]           sym_ext;
	logic                 seg_ok;
	logic                 sym_ok;
	logic [31:0]          seg_base;
	logic [31:0]          sym_base;
	res_push_t            push;
	logic [1:0]           stage_busy;
	logic [RES_CNT_W-1:0] fill;
	logic [RES_CNT_W:0]   committed;

	// Worst case every request in flight makes two writes. Admit a request only when
	// the queue can still take two writes from each stage plus two from the new one.
	assign committed = (RES_CNT_W+1)'(fill)
		+ (RES_CNT_W+1)'({stage_busy[0], 1'b0})
		+ (RES_CNT_W+1)'({stage_busy[1], 1'b0});
	assign req_stall = committed > (RES_CNT_W+1)'(RES_DEPTH - 2);
	assign accept    = req_valid && !req_stall;

	// an index past the table reads as base zero; a set-base there is dropped
	assign seg_ext = 9'(req_data.seg_index);
	assign sym_ext = 9'(req_data.symbol_index);
	assign seg_ok  = seg_ext < 9'(SEGMENTS);
	assign sym_ok  = sym_ext < 9'(SEGMENTS);

	// Writes land at the accept edge and reads sample at the accept edge of the next
	// request, so a base set by one request is seen by the very next one.
	mrp_seg_mem #(
		.SEGMENTS(SEGMENTS)
	) u_seg_mem (
		.clk      (clk),
		.wr_en    (accept && req_data.func == FUNC_SET_BASE && seg_ok),
		.wr_idx   (seg_ext[IDX_W-1:0]),
		.wr_data  (req_data.base_value),
		.rd_en    (accept),
		.rd_idx_a (seg_ext[IDX_W-1:0]),
		.rd_idx_b (sym_ext[IDX_W-1:0]),
		.rd_data_a(seg_base),
		.rd_data_b(sym_base)
	);

	// advance unconditionally; the admission check above keeps the queue from filling
	mrp_reloc_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req_data),
		.seg_ok    (seg_ok),
		.sym_ok    (sym_ok),
		.seg_base  (seg_base),
		.sym_base  (sym_base),
		.push      (push),
		.stage_busy(stage_busy)
	);

	mrp_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data),
		.fill     (fill)
	);

	`MRP_ASSERT(a_credit, clk, arst_n, committed <= (RES_CNT_W+1)'(RES_DEPTH), "queue credit broken")

endmodule

### tb/mips_relocation_patcher_unit_tb.sv
`timescale 1ns / 1ps

module mips_relocation_patcher_unit_tb import mrp_pkg::*; ();

	// codes the package leaves unnamed
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [7:0] RT_NONE     = 8'd0;

	localparam int RELOC_ITEMS  = 1750;
	localparam int HOLD_AT      = 400;     // result count that starts the long receiver hold
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 20;      // quiet cycles after the last write
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		req_t req;
		logic drain_first;    // hold this request until every write is back
	} reloc_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	mips_relocation_patcher_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Request stream built up front, and the writes the patcher owes us.
	reloc_item_t reloc_stream[$];
	res_t due_writes[$];

	// Stimulus bookkeeping: which table entries have been loaded so far.
	logic [31:0] seg_written = '0;
	int useful_count = 0;
	logic drain_next = 1'b0;

	// Shadow of the patcher state.
	logic [31:0] base_tab [SEGMENTS_DEF];
	logic [31:0] hi_addr_q = '0;
	logic [15:0] hi_half_q = '0;
	logic hi_armed = 1'b0;

	int err_count = 0;
	int cycle_count = 0;

	function automatic void owe_write(input logic [31:0] addr, input logic [31:0] data,
		input logic half, input logic fin);
		res_t w;
		w.write_addr = addr;
		w.write_data = data;
		w.write_half = half;
		w.last = fin;
		due_writes.push_back(w);
	endfunction

	// Apply one accepted request to the shadow state and queue the writes it causes.
	function automatic void predict_patch(input req_t r);
		logic [31:0] addr;
		logic [31:0] v;
		addr = base_tab[r.seg_index] + r.target_offset;
		v = base_tab[r.symbol_index];
		case (r.func)
			FUNC_SET_BASE: begin
				base_tab[r.seg_index] = r.base_value;
			end
			FUNC_SECTION: begin
				// forget the open HI16 but keep its halfword for orphans
				hi_armed = 1'b0;
				hi_addr_q = '0;
			end
			FUNC_APPLY: begin
				case (r.reloc_type)
					RT_R16: begin
						v[15:0] = v[15:0] + r.target_value[15:0];
						owe_write(addr, {16'h0, v[15:0]}, 1'b1, 1'b1);
					end
					RT_R32: owe_write(addr, v + r.target_value, 1'b0, 1'b1);
					RT_REL32: owe_write(addr, v + r.target_value - addr, 1'b0, 1'b1);
					RT_R26: begin
						v = v + {r.target_value[25:0], 2'b00};
						owe_write(addr, {r.target_value[31:26], v[27:2]}, 1'b0, 1'b1);
					end
					RT_HI16: begin
						hi_addr_q = addr;
						hi_half_q = r.target_value[15:0];
						hi_armed = 1'b1;
					end
					RT_LO16: begin
						v = v + {hi_half_q, r.target_value[15:0]};
						if (hi_armed) begin
							// round the HI half up when the LO half reads negative
							if (v[15])
								v = v + 32'h0001_0000;
							owe_write(hi_addr_q, {16'h0, v[31:16]}, 1'b1, 1'b0);
							hi_armed = 1'b0;
						end
						owe_write(addr, {16'h0, v[15:0]}, 1'b1, 1'b1);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	// Stimulus helpers -------------------------------------------------------

	function automatic req_t noise_req();
		req_t r;
		r.func = 2'($urandom);
		r.seg_index = 5'($urandom);
		r.base_value = $urandom;
		r.reloc_type = 8'($urandom);
		r.symbol_index = 5'($urandom);
		r.target_offset = $urandom;
		r.target_value = $urandom;
		return r;
	endfunction

	// Random word, leaning on the edges that expose carries and wraps.
	function automatic logic [31:0] wide_val();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h0000_7fff;
			3: return 32'h0000_8000;
			4: return 32'hffff_8000;
			default: return $urandom;
		endcase
	endfunction

	// Only loaded table entries may be read.
	function automatic logic [4:0] pick_seg();
		logic [4:0] s;
		do
			s = 5'($urandom);
		while (!seg_written[s]);
		return s;
	endfunction

	task automatic add_req(input req_t r);
		reloc_item_t it;
		it.req = r;
		it.drain_first = drain_next;
		drain_next = 1'b0;
		reloc_stream.push_back(it);
		if (r.func == FUNC_SET_BASE)
			seg_written[r.seg_index] = 1'b1;
		if (!(r.func == FUNC_UNUSED ||
			(r.func == FUNC_APPLY && (r.reloc_type == RT_NONE || r.reloc_type > RT_LO16))))
			useful_count++;
	endtask

	task automatic add_base(input logic [4:0] seg, input logic [31:0] val);
		req_t r;
		r = noise_req();
		r.func = FUNC_SET_BASE;
		r.seg_index = seg;
		r.base_value = val;
		add_req(r);
	endtask

	task automatic add_apply(input logic [7:0] rt, input logic [4:0] seg, input logic [4:0] sym,
		input logic [31:0] off, input logic [31:0] tv);
		req_t r;
		r = noise_req();
		r.func = FUNC_APPLY;
		r.reloc_type = rt;
		r.seg_index = seg;
		r.symbol_index = sym;
		r.target_offset = off;
		r.target_value = tv;
		add_req(r);
	endtask

	task automatic add_section();
		req_t r;
		r = noise_req();
		r.func = FUNC_SECTION;
		add_req(r);
	endtask

	task automatic add_rand_apply(input logic [7:0] rt);
		add_apply(rt, pick_seg(), pick_seg(), wide_val(), wide_val());
	endtask

	// Requests the patcher must swallow without a trace.
	task automatic add_noise();
		req_t r;
		if ($urandom_range(0, 1)) begin
			r = noise_req();
			r.func = FUNC_UNUSED;
			add_req(r);
		end else begin
			add_rand_apply($urandom_range(0, 3) == 0 ? RT_NONE : 8'($urandom_range(7, 255)));
		end
	endtask

	// Driver: offer the next request, hold it while stalled, and at times idle between requests.
	int send_wait = 0;
	logic send_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		logic offer;
		req_t nxt;
		reloc_item_t it;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			send_wait = 0;
		end else begin
			offer = req_valid;
			nxt = req_data;
			if (req_valid && !req_stall) begin
				predict_patch(req_data);
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (reloc_stream.size() != 0 &&
					(!reloc_stream[0].drain_first || due_writes.size() == 0)) begin
					it = reloc_stream.pop_front();
					nxt = it.req;
					offer = 1'b1;
					// draw the gap that follows this request; toggle bursts now and then
					if ($urandom_range(0, 49) == 0)
						send_burst = !send_burst;
					send_wait = send_burst ? 0 : $urandom_range(0, 7);
				end
			end
			req_valid <= offer;
			req_data <= nxt;
		end
	end

	// Monitor: check each accepted write against the oldest one owed, and stall at random.
	int recv_wait = 0;
	int hold_left = 0;
	int writes_seen = 0;
	logic recv_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				writes_seen++;
				if (due_writes.size() == 0) begin
					$error("unexpected write: addr %h data %h half %b last %b",
						res_data.write_addr, res_data.write_data, res_data.write_half,
						res_data.last);
					err_count++;
				end else begin
					want = due_writes.pop_front();
					if (res_data.write_addr !== want.write_addr) begin
						$error("write_addr: expected %h, got %h", want.write_addr,
							res_data.write_addr);
						err_count++;
					end
					if (res_data.write_data !== want.write_data) begin
						$error("write_data: expected %h, got %h", want.write_data,
							res_data.write_data);
						err_count++;
					end
					if (res_data.write_half !== want.write_half) begin
						$error("write_half: expected %b, got %b", want.write_half,
							res_data.write_half);
						err_count++;
					end
					if (res_data.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, res_data.last);
						err_count++;
					end
				end
				if ($urandom_range(0, 49) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 7);
				// once, shut the output long enough for the patcher to back up into its input
				if (writes_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic drain_set;
		logic [31:0] sec;
		drain_set = 1'b0;

		// Directed: load a few segments at the extremes, then touch every type.
		add_base(5'd0, 32'h0000_0000);
		add_base(5'd31, 32'hffff_ffff);
		add_base(5'd1, 32'h8000_0000);
		add_base(5'd2, 32'h0001_8000);
		add_base(5'd30, 32'h1234_5678);
		add_apply(RT_R16, 5'd31, 5'd31, 32'h0000_0000, 32'hffff_ffff);
		add_apply(RT_R32, 5'd0, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
		add_apply(RT_REL32, 5'd1, 5'd0, 32'h8000_0000, 32'h0000_0000);
		add_apply(RT_R26, 5'd2, 5'd31, 32'h0000_0004, 32'hffff_ffff);
		add_apply(RT_R26, 5'd0, 5'd1, 32'h0000_0000, 32'h0000_0000);
		// HI16 resolved by a LO16 whose low half carries into the HI half
		add_apply(RT_HI16, 5'd30, 5'd0, 32'h0000_0100, 32'h0000_7fff);
		add_apply(RT_LO16, 5'd2, 5'd2, 32'h0000_0104, 32'h0000_8000);
		// orphan LO16 picks up the stale HI halfword
		add_apply(RT_LO16, 5'd2, 5'd0, 32'h0000_0108, 32'h0000_ffff);
		// a second HI16 replaces the first before any LO16
		add_apply(RT_HI16, 5'd1, 5'd0, 32'h0000_0000, 32'hffff_ffff);
		add_apply(RT_HI16, 5'd0, 5'd30, 32'h0000_0010, 32'h0001_0001);
		add_apply(RT_LO16, 5'd0, 5'd30, 32'h0000_0014, 32'h0000_7fff);
		// section start cancels a HI16
		add_apply(RT_HI16, 5'd31, 5'd0, 32'h0000_0020, 32'h0000_1234);
		add_section();
		add_apply(RT_LO16, 5'd31, 5'd0, 32'h0000_0024, 32'h0000_8001);
		// ignored types and the unused function
		add_apply(RT_NONE, 5'd0, 5'd0, 32'h0, 32'h0);
		add_apply(8'd7, 5'd1, 5'd2, 32'hffff_ffff, 32'hffff_ffff);
		add_apply(8'd255, 5'd31, 5'd31, 32'h0, 32'hffff_ffff);
		add_noise();
		// wrap of the full sum on a resolved pair
		add_apply(RT_HI16, 5'd31, 5'd31, 32'hffff_fffe, 32'hffff_ffff);
		add_apply(RT_LO16, 5'd31, 5'd31, 32'hffff_fffc, 32'hffff_ffff);

		// Random: mostly HI16/LO16 chains of random content, mixed with singles, sections and junk.
		while (useful_count < RELOC_ITEMS) begin
			if (!drain_set && useful_count >= RELOC_ITEMS / 2) begin
				drain_next = 1'b1;
				drain_set = 1'b1;
			end
			case ($urandom_range(0, 19))
				0, 1: add_base(5'($urandom), wide_val());
				2, 3, 4, 5, 6, 7, 8, 9: begin
					if ($urandom_range(0, 7) == 0)
						add_section();
					add_rand_apply(RT_HI16);
					sec = $urandom_range(1, 3);
					repeat (sec) begin
						if ($urandom_range(0, 5) == 0)
							add_rand_apply(8'($urandom_range(RT_R16, RT_R26)));
						add_rand_apply(RT_LO16);
					end
				end
				10, 11, 12, 13, 14, 15: add_rand_apply(8'($urandom_range(RT_R16, RT_R26)));
				16: add_rand_apply(RT_LO16);
				17: add_section();
				18: begin
					add_rand_apply(RT_HI16);
					add_section();
					add_rand_apply(RT_LO16);
				end
				default: add_noise();
			endcase
		end

		// Release reset away from the active edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go in and every owed write to come back.
		while (reloc_stream.size() != 0 || req_valid || due_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/mrp_pkg.sv
sv/mrp_seg_mem.sv
sv/mrp_reloc_pipe.sv
sv/mrp_result_fifo.sv
sv/mips_relocation_patcher_unit.sv
tb/mips_relocation_patcher_unit_tb.sv
